// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, expr)

`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/wbps_pkg.sv -----
`timescale 1ns / 1ps

package wbps_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int REG_BYTES     = 16;
   localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
   localparam int IDX_W         = $clog2(REG_BYTES);
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int COUNT_W       = 32;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CARE_MASK      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

   typedef struct packed {
      logic [7:0] expect_byte;
      logic       care;
   } cell_cfg_type;

   function automatic logic [LEN_W-1:0] effective_length(input logic [4:0] len);
      logic [LEN_W-1:0] res;
      if (len == 5'd0) begin
         res = LEN_W'(1);
      end else if (32'(len) > PATTERN_BYTES) begin
         res = LEN_W'(PATTERN_BYTES);
      end else begin
         res = LEN_W'(len);
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/wbps_cell.sv -----
`timescale 1ns / 1ps

module wbps_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  flush,
   input  logic [7:0]            byte_in,
   input  wbps_pkg::cell_cfg_type cfg,
   output logic [7:0]            byte_out,
   output logic                  hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_sel;
   logic [7:0] byte_next;

   assign byte_in_sel = flush ? 8'd0 : byte_in;
   assign byte_next   = shift_en ? byte_in_sel : byte_ff;
   assign hit         = !cfg.care || (byte_next == cfg.expect_byte);
   assign byte_out    = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_next;
      end
   end

endmodule

// ----- rtl/core/wildcard_byte_pattern_scanner_top.sv -----
`timescale 1ns / 1ps

// Streams one section byte per cycle (req_tuser marks the first byte, req_tlast the last)
// and returns at most one result per section: rsp_tuser=1 with the start offset of the
// first full match in rsp_tdata, or rsp_tuser=0 with offset 0 on the last byte when the
// pattern was not seen. A byte is taken every cycle unless a result waits in the output
// register with rsp_tready low; that register is refilled in the cycle it is drained. The
// result appears in the output register the cycle after the byte that caused it, set by the
// single compare stage of the 16-cell window chain. Bytes after a section's result are
// dropped until the next first byte. Program the pattern, care mask and length over the
// csr port only while idle.

`include "assert_macros.svh"

module wildcard_byte_pattern_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // match_offset
   output logic        rsp_tuser,   // found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int PB = wbps_pkg::PATTERN_BYTES;
   localparam int LW = wbps_pkg::LEN_W;
   localparam int CW = wbps_pkg::COUNT_W;

   logic [2*wbps_pkg::CSR_DATA_W-1:0] pattern_ff;
   logic [wbps_pkg::REG_BYTES-1:0]    mask_ff;
   logic [4:0]                        length_ff;

   logic [CW-1:0] count_ff, count_in, count_base;
   logic          done_ff, done_in, done_base;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [CW-1:0] rsp_offset_ff, rsp_offset_in;

   logic          req_take, active, all_hit, match, emit;
   logic [LW-1:0] eff_len;
   logic [7:0]    cell_byte [PB];
   logic [PB-1:0] cell_hit;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign eff_len    = wbps_pkg::effective_length(length_ff);

   assign count_base = req_tuser ? '0 : count_ff;
   assign done_base  = req_tuser ? 1'b0 : done_ff;
   assign active     = req_take && !done_base;

   for (genvar j = 0; j < PB; j++) begin : g_cell
      wbps_pkg::cell_cfg_type cfg;
      logic [LW-1:0]          idx;
      logic [7:0]             chain_in;

      assign idx = eff_len - LW'(1) - LW'(j);
      assign cfg.care = (LW'(j) < eff_len) && (32'(idx) < wbps_pkg::REG_BYTES)
                        && mask_ff[idx[wbps_pkg::IDX_W-1:0]];
      assign cfg.expect_byte = pattern_ff[8*idx[wbps_pkg::IDX_W-1:0] +: 8];

      if (j == 0) begin : g_head
         assign chain_in = req_tdata;
      end else begin : g_body
         assign chain_in = cell_byte[j-1];
      end

      wbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (active),
         .flush    ((j != 0) && req_tuser),
         .byte_in  (chain_in),
         .cfg      (cfg),
         .byte_out (cell_byte[j]),
         .hit      (cell_hit[j])
      );
   end

   assign all_hit = &cell_hit;

   always_comb begin
      count_in      = count_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      match         = 1'b0;
      emit          = 1'b0;
      if (req_take) begin
         count_in = count_base;
         done_in  = done_base;
         if (active) begin
            if (count_base != {CW{1'b1}}) begin
               count_in = count_base + CW'(1);
            end
            match = (count_in >= CW'(eff_len)) && all_hit;
            emit  = match || req_tlast;
            if (emit) begin
               done_in       = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = match;
               rsp_offset_in = match ? (count_in - CW'(eff_len)) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mask_ff    <= '0;
         length_ff  <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wbps_pkg::REG_PATTERN_LOW:    pattern_ff[63:0]   <= csr_data;
            wbps_pkg::REG_PATTERN_HIGH:   pattern_ff[127:64] <= csr_data;
            wbps_pkg::REG_CARE_MASK:      mask_ff   <= csr_data[wbps_pkg::REG_BYTES-1:0];
            wbps_pkg::REG_PATTERN_LENGTH: length_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

   `ASSERT_ALWAYS(a_miss_zero, clock, reset, !(rsp_valid_ff && !rsp_found_ff) || (rsp_offset_ff == '0))
   `ASSERT_NEXT(a_emit_done, clock, reset, emit, done_ff && rsp_valid_ff)
   `ASSERT_NEXT(a_idle_hold, clock, reset, req_take && done_base, $stable(count_ff) && done_ff)
   `ASSERT_NEXT(a_count_up, clock, reset, req_take && !req_tuser, count_ff >= $past(count_ff))

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_PAD       = 4;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ROUND_BYTES    = 9;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } scan_hit_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] care;
      logic [4:0]  len;
   } scan_cfg_type;

   typedef enum logic {ROW_BYTE, ROW_CONFIG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         first;
      logic         last;
      logic         typed;
      scan_hit_type hit;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = wbps_pkg::REG_PATTERN_LOW;
   logic [63:0] csr_data = 64'd0;

   // scanner model state and register copy
   logic [7:0]  win [wbps_pkg::PATTERN_BYTES];
   logic [31:0] seen_count;
   logic        sect_closed;
   logic [63:0] cfg_lo;
   logic [63:0] cfg_hi;
   logic [15:0] cfg_care;
   logic [4:0]  cfg_len;

   scan_hit_type expected_hits [$];
   scan_hit_type rsp_want;
   int unsigned sent_bytes = 0;
   int unsigned error_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned hold_left = 0;
   int unsigned req_idle_pct = 26;
   int unsigned rsp_idle_pct = 66;
   logic        rsp_hold_req = 1'b0;

   scan_cfg_type dir_cfgs [3] = '{
      '{64'h0000_0000_0080_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0007, 5'd3},
      '{64'h0000_0000_0080_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0007, 5'd0},
      '{64'h0000_0000_0080_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0007, 5'd31}
   };

   dir_row_type directed_rows [25] = '{
      '{ROW_BYTE,   8'hFF, 1'b1, 1'b0, 1'b1, '{1'b1, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h5A, 1'b1, 1'b1, 1'b1, '{1'b1, 32'd0}},
      '{ROW_CONFIG, 8'd0,  1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h11, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 1'b1, '{1'b1, 32'd1}},
      '{ROW_BYTE,   8'h00, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b1, 1'b1, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h80, 1'b0, 1'b1, 1'b1, '{1'b1, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 1'b1, '{1'b1, 32'd0}},
      '{ROW_BYTE,   8'h80, 1'b1, 1'b1, 1'b1, '{1'b0, 32'd0}},
      '{ROW_CONFIG, 8'd1,  1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h7F, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b0, 1'b0, 1'b1, '{1'b1, 32'd1}},
      '{ROW_CONFIG, 8'd2,  1'b0, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'h00, 1'b1, 1'b0, 1'b0, '{1'b0, 32'd0}},
      '{ROW_BYTE,   8'hFF, 1'b0, 1'b1, 1'b1, '{1'b0, 32'd0}}
   };

   wildcard_byte_pattern_scanner_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned eff_len(input logic [4:0] len);
      if (len == 5'd0) return 1;
      if (len > wbps_pkg::PATTERN_BYTES) return wbps_pkg::PATTERN_BYTES;
      return len;
   endfunction

   function automatic logic [7:0] pattern_at(input int unsigned k);
      return (k < 8) ? cfg_lo[8*k +: 8] : cfg_hi[8*(k-8) +: 8];
   endfunction

   task automatic scan_predict(input logic [7:0] b, input logic first, input logic last,
                               output logic emits, output scan_hit_type hit);
      int unsigned span;
      int unsigned k;
      logic        ok;
      emits = 1'b0;
      hit = '0;
      if (first) begin
         win = '{default: 8'h00};
         seen_count = 32'd0;
         sect_closed = 1'b0;
      end
      if (!sect_closed) begin
         for (k = wbps_pkg::PATTERN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
         win[0] = b;
         if (seen_count != 32'hFFFF_FFFF) seen_count = seen_count + 32'd1;
         span = eff_len(cfg_len);
         ok = 1'b1;
         for (k = 0; k < span; k++) begin
            if (cfg_care[k] && win[span-1-k] != pattern_at(k)) ok = 1'b0;
         end
         if (seen_count >= span && ok) begin
            emits = 1'b1;
            sect_closed = 1'b1;
            hit = '{1'b1, seen_count - 32'(span)};
         end else if (last) begin
            emits = 1'b1;
            sect_closed = 1'b1;
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic typed, input scan_hit_type typed_hit);
      logic         emits;
      scan_hit_type hit;
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      scan_predict(b, first, last, emits, hit);
      if (typed) expected_hits.push_back(typed_hit);
      else if (emits) expected_hits.push_back(hit);
      sent_bytes++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (IDLE_PAD) @(posedge clock);
   endtask

   task automatic csr_put(input logic [wbps_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input scan_cfg_type cfg);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      csr_put(wbps_pkg::REG_PATTERN_LOW, cfg.lo);
      csr_put(wbps_pkg::REG_PATTERN_HIGH, cfg.hi);
      csr_put(wbps_pkg::REG_CARE_MASK, {noise[63:16], cfg.care});
      csr_put(wbps_pkg::REG_PATTERN_LENGTH, {noise[63:5], cfg.len});
      csr_valid <= 1'b0;
      cfg_lo = cfg.lo;
      cfg_hi = cfg.hi;
      cfg_care = cfg.care;
      cfg_len = cfg.len;
   endtask

   // one section with the pattern planted most of the time, sometimes cut off by the end
   task automatic send_section(input bit allow_open);
      logic [7:0]  bytes [64];
      int unsigned span;
      int unsigned n;
      int unsigned pos;
      int unsigned k;
      bit          open_end;
      span = eff_len(cfg_len);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, span + 10);
      for (k = 0; k < n; k++) begin
         bytes[k] = ($urandom_range(0, 3) == 0) ? pattern_at($urandom_range(0, span - 1))
                                                : 8'($urandom);
      end
      if ($urandom_range(0, 9) < 7) begin
         pos = (n >= span && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - span)
                                                        : $urandom_range(0, n - 1);
         for (k = 0; k < span && pos + k < n; k++) begin
            if (cfg_care[k]) bytes[pos+k] = pattern_at(k);
         end
      end
      open_end = allow_open && ($urandom_range(0, 9) == 0);
      for (k = 0; k < n; k++) send_byte(bytes[k], k == 0, !open_end && k == n - 1, 1'b0, '0);
      if (!open_end && $urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom), 1'b0, '0);
      end
   endtask

   // receiver side: random backpressure plus a long hold when rsp_hold_req is set
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_hold_req) begin
         hold_left <= HOLD_CYCLES;
         rsp_hold_req <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result transaction: found %0b offset %0d",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            rsp_want = expected_hits.pop_front();
            if (rsp_tuser !== rsp_want.found) begin
               $display("%0t: found mismatch: expected %0b, actual %0b",
                        $time, rsp_want.found, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== rsp_want.offset) begin
               $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                        $time, rsp_want.offset, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("** wildcard_byte_pattern_scanner_top: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned  mode;
      int unsigned  round;
      int unsigned  i;
      int unsigned  target;
      scan_cfg_type cfg;
      win = '{default: 8'h00};
      seen_count = 32'd0;
      sect_closed = 1'b0;
      cfg_lo = 64'd0;
      cfg_hi = 64'd0;
      cfg_care = 16'h0000;
      cfg_len = 5'd1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 25; i++) begin
         if (directed_rows[i].kind == ROW_CONFIG) begin
            wait_idle();
            write_config(dir_cfgs[directed_rows[i].data]);
         end else begin
            send_byte(directed_rows[i].data, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].hit);
         end
      end

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 26;
               rsp_idle_pct = 66;
            end
            1: begin
               req_idle_pct = 66;
               rsp_idle_pct = 26;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (round = 0; round < 6; round++) begin
            wait_idle();
            cfg.lo = {$urandom, $urandom};
            cfg.hi = {$urandom, $urandom};
            case (round)
               0: begin
                  cfg.care = 16'hFFFF;
                  cfg.len = 5'd16;
               end
               1: begin
                  cfg.care = 16'($urandom);
                  cfg.len = (mode == 1) ? 5'd0 : 5'($urandom_range(17, 31));
               end
               2: begin
                  cfg.care = 16'h0000;
                  cfg.len = 5'($urandom_range(1, 16));
               end
               default: begin
                  cfg.care = 16'($urandom);
                  cfg.len = 5'($urandom_range(1, 8));
               end
            endcase
            write_config(cfg);
            target = sent_bytes + ROUND_BYTES;
            while (sent_bytes < target) send_section(1'b1);
            send_section(1'b0);
         end
      end

      // every one-byte section yields a result, so a long hold backs up the input
      wait_idle();
      write_config('{{$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd1});
      rsp_hold_req <= 1'b1;
      repeat (40) send_byte(8'($urandom), 1'b1, 1'b1, 1'b0, '0);

      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (2 * IDLE_PAD) @(posedge clock);
      if (error_count == 0) begin
         $display("** wildcard_byte_pattern_scanner_top: PASSED **");
      end else begin
         $display("** wildcard_byte_pattern_scanner_top: FAILED **");
      end
      $finish;
   end

endmodule
